// ----- hdl/gbn_pkg.sv -----
package gbn_pkg;
   localparam int MAX_BOXES  = 64;
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int IDX_BITS   = $clog2(MAX_BOXES);
   localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
   localparam int SCORE_BITS = 16;
   localparam int THR_BITS   = 9;
   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(115);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]  w;
      logic [SIZE_BITS-1:0]  h;
   } box_type;
endpackage

// ----- hdl/greedy_box_nms.sv -----
// channel | dir | handshake          | word
// req_    | in  | start & !busy      | one box, final_box starts suppression
// rsp_    | out | rsp_strobe, 1 cyc  | one kept box or the none-kept marker
// csr_    | in  | csr_valid&csr_ready| overlap threshold
// Loading accepts one box per cycle while idle. Suppression visits the boxes
// in score order: for each, a scan through the score memory finds the next box,
// which is latched as the candidate, compared against each kept box in turn
// through the single read port of the box memory, and appended to the kept list
// when it survives. Output has a setup state, then reads and sends the kept
// list one word at a time. Reset is synchronous; the stores need no clearing.
// The receiver cannot stall; busy holds off start and the csr write.
module greedy_box_nms
   import gbn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [COORD_BITS-1:0] req_box_x,
   input  logic [COORD_BITS-1:0] req_box_y,
   input  logic [SIZE_BITS-1:0]  req_box_width,
   input  logic [SIZE_BITS-1:0]  req_box_height,
   input  logic [SCORE_BITS-1:0] req_score,
   input  logic                  req_final_box,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [THR_BITS-1:0]   csr_data,
   output logic                  rsp_strobe,
   output logic [COORD_BITS-1:0] rsp_kept_x,
   output logic [COORD_BITS-1:0] rsp_kept_y,
   output logic [SIZE_BITS-1:0]  rsp_kept_width,
   output logic [SIZE_BITS-1:0]  rsp_kept_height,
   output logic [SCORE_BITS-1:0] rsp_kept_score,
   output logic                  rsp_last_kept,
   output logic                  rsp_none_kept,
   output logic                  rsp_overflowed
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCANW = 4'd2, S_CAND = 4'd3,
                          S_KRD = 4'd4, S_KWAIT = 4'd5, S_CMP1 = 4'd6, S_MUL = 4'd7,
                          S_CMP2 = 4'd8, S_KEEP = 4'd9, S_ORD = 4'd10, S_ORDW = 4'd11,
                          S_OUT = 4'd12, S_NONE = 4'd13;

   box_type               box_mem [MAX_BOXES];
   logic [SCORE_BITS-1:0] score_mem [MAX_BOXES];
   logic [IDX_BITS-1:0]   order_mem [MAX_BOXES];

   logic [3:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  ovf_ff;
   logic [THR_BITS-1:0]   thr_ff;
   logic [CNT_BITS-1:0]   scan_ff, nkept_ff, k_ff;
   logic [IDX_BITS-1:0]   best_ff, rd_idx_ff, prev_idx_ff;
   logic                  best_v_ff, rd_v_ff, prev_v_ff;
   logic [SCORE_BITS-1:0] best_sc_ff, prev_sc_ff;
   box_type               cand_ff, rbox_ff;
   logic [SCORE_BITS-1:0] rscore_ff;
   logic [IDX_BITS-1:0]   rord_ff;
   logic [COORD_BITS+1:0] iw_ff, ih_ff;
   logic [2*SIZE_BITS-1:0] aa_ff, ab_ff;
   logic [2*COORD_BITS+3:0] inter_ff;

   // memory address and write
   logic [IDX_BITS-1:0]   box_ra, ord_ra, sc_ra;
   logic                  load, load_ok, store_ok, last_out;
   assign load = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign csr_ready = !busy;
   assign load_ok = req_box_width != '0 && req_box_height != '0;
   assign store_ok = load && load_ok && count_ff < CNT_BITS'(MAX_BOXES);
   assign last_out = CNT_BITS'(k_ff + 1'b1) == nkept_ff;

   always_ff @(posedge clock) begin
      if (store_ok) begin
         box_mem[count_ff[IDX_BITS-1:0]] <= '{req_box_x, req_box_y, req_box_width, req_box_height};
         score_mem[count_ff[IDX_BITS-1:0]] <= req_score;
      end
      if (state_ff == S_KEEP)
         order_mem[nkept_ff[IDX_BITS-1:0]] <= best_ff;
      rbox_ff   <= box_mem[box_ra];
      rscore_ff <= score_mem[sc_ra];
      rord_ff   <= order_mem[ord_ra];
   end

   // overlap math
   logic [COORD_BITS+1:0] ea, eb, lo, hi, ea2, eb2, lo2, hi2;
   logic [2*COORD_BITS+3:0] uni;
   logic [2*COORD_BITS+12:0] lhs, rhs;
   logic suppress_w;
   always_comb begin
      lo  = (COORD_BITS+2)'(cand_ff.x > rbox_ff.x ? cand_ff.x : rbox_ff.x);
      ea  = (COORD_BITS+2)'(cand_ff.x) + (COORD_BITS+2)'(cand_ff.w);
      eb  = (COORD_BITS+2)'(rbox_ff.x) + (COORD_BITS+2)'(rbox_ff.w);
      hi  = ea < eb ? ea : eb;
      lo2 = (COORD_BITS+2)'(cand_ff.y > rbox_ff.y ? cand_ff.y : rbox_ff.y);
      ea2 = (COORD_BITS+2)'(cand_ff.y) + (COORD_BITS+2)'(cand_ff.h);
      eb2 = (COORD_BITS+2)'(rbox_ff.y) + (COORD_BITS+2)'(rbox_ff.h);
      hi2 = ea2 < eb2 ? ea2 : eb2;
      uni = (2*COORD_BITS+4)'(aa_ff) + (2*COORD_BITS+4)'(ab_ff) - inter_ff;
      lhs = {inter_ff, 8'd0};
      rhs = (2*COORD_BITS+13)'(thr_ff) * (2*COORD_BITS+13)'(uni);
      suppress_w = inter_ff != '0 && lhs > rhs;
   end

   // next box in score order comes after the previous pick: lower score, or
   // equal score and later arrival
   logic after_prev;
   assign after_prev = !prev_v_ff || rscore_ff < prev_sc_ff ||
                       (rscore_ff == prev_sc_ff && rd_idx_ff > prev_idx_ff);

   always_comb begin
      box_ra = best_ff;
      if (state_ff == S_KWAIT || state_ff == S_CMP1 || state_ff == S_ORDW) box_ra = rord_ff;
      sc_ra = scan_ff[IDX_BITS-1:0];
      if (state_ff == S_SCAN) sc_ra = '0;
      if (state_ff == S_ORDW) sc_ra = rord_ff;
      ord_ra = k_ff[IDX_BITS-1:0];
      if (state_ff == S_ORD) ord_ra = '0;
      if (state_ff == S_OUT) ord_ra = IDX_BITS'(k_ff + 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (load && req_final_box) state_in = S_SCAN;
         S_SCAN:  state_in = S_SCANW;
         S_SCANW: if (!rd_v_ff) state_in = best_v_ff ? S_CAND : S_ORD;
         S_CAND:  state_in = S_KRD;
         S_KRD:   state_in = (k_ff == nkept_ff) ? S_KEEP : S_KWAIT;
         S_KWAIT: state_in = S_CMP1;
         S_CMP1:  state_in = S_MUL;
         S_MUL:   state_in = S_CMP2;
         S_CMP2:  state_in = suppress_w ? S_SCAN : S_KRD;
         S_KEEP:  state_in = S_SCAN;
         S_ORD:   state_in = (nkept_ff == '0) ? S_NONE : S_ORDW;
         S_ORDW:  state_in = S_OUT;
         S_OUT:   state_in = last_out ? S_IDLE : S_ORDW;
         S_NONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         thr_ff <= THR_RESET;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe <= state_ff == S_OUT || state_ff == S_NONE;
         if (csr_valid && csr_ready) thr_ff <= csr_data;
         if (load && load_ok) begin
            if (count_ff < CNT_BITS'(MAX_BOXES)) count_ff <= count_ff + 1'b1;
            else ovf_ff <= 1'b1;
         end
         if ((state_ff == S_OUT && last_out) || state_ff == S_NONE) begin
            count_ff <= '0; ovf_ff <= 1'b0;
         end
      end
   end

   // datapath (no reset)
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            nkept_ff <= '0; prev_v_ff <= 1'b0;
         end
         S_SCAN: begin
            scan_ff <= (count_ff != '0) ? CNT_BITS'(1) : '0;
            rd_idx_ff <= '0; rd_v_ff <= count_ff != '0; best_v_ff <= 1'b0;
         end
         S_SCANW: begin
            // rscore_ff holds score of rd_idx_ff
            if (rd_v_ff && after_prev && (!best_v_ff || rscore_ff > best_sc_ff)) begin
               best_v_ff <= 1'b1; best_ff <= rd_idx_ff; best_sc_ff <= rscore_ff;
            end
            rd_idx_ff <= scan_ff[IDX_BITS-1:0];
            rd_v_ff <= scan_ff != count_ff;
            if (scan_ff != count_ff) scan_ff <= scan_ff + 1'b1;
         end
         S_CAND: begin
            cand_ff <= rbox_ff; k_ff <= '0;
            aa_ff <= rbox_ff.w * rbox_ff.h;
            prev_v_ff <= 1'b1; prev_idx_ff <= best_ff; prev_sc_ff <= best_sc_ff;
         end
         S_CMP1: begin
            iw_ff <= hi > lo ? hi - lo : '0;
            ih_ff <= hi2 > lo2 ? hi2 - lo2 : '0;
            ab_ff <= rbox_ff.w * rbox_ff.h;
         end
         S_MUL: inter_ff <= iw_ff * ih_ff;
         S_CMP2: k_ff <= k_ff + 1'b1;
         S_KEEP: nkept_ff <= nkept_ff + 1'b1;
         S_ORD: k_ff <= '0;
         S_OUT: begin
            rsp_kept_x <= rbox_ff.x; rsp_kept_y <= rbox_ff.y;
            rsp_kept_width <= rbox_ff.w; rsp_kept_height <= rbox_ff.h;
            rsp_kept_score <= rscore_ff;
            rsp_last_kept <= last_out;
            rsp_none_kept <= 1'b0;
            rsp_overflowed <= ovf_ff;
            k_ff <= k_ff + 1'b1;
         end
         S_NONE: begin
            rsp_kept_x <= '0; rsp_kept_y <= '0; rsp_kept_width <= '0;
            rsp_kept_height <= '0; rsp_kept_score <= '0;
            rsp_last_kept <= 1'b1;
            rsp_none_kept <= 1'b1;
            rsp_overflowed <= ovf_ff;
         end
         default: ;
      endcase
   end
endmodule

// ----- hdl/gbn_checker.sv -----
module gbn_checker
   import gbn_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last_kept,
   input logic rsp_none_kept,
   input logic [SCORE_BITS-1:0] rsp_kept_score
);
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_none_kept |-> rsp_last_kept) else $error("none without last");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_none_kept |-> rsp_kept_score == '0) else $error("none nonzero");
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_kept |-> busy) else $error("idle mid run");
endmodule

bind greedy_box_nms gbn_checker u_chk (.*);

// ----- test/tb_greedy_box_nms.sv -----
`timescale 1ns / 100ps

module tb_greedy_box_nms;
   import gbn_pkg::*;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]  w;
      logic [SIZE_BITS-1:0]  h;
      logic [SCORE_BITS-1:0] score;
      logic                  fin;
   } box_word;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [SIZE_BITS-1:0]  w;
      logic [SIZE_BITS-1:0]  h;
      logic [SCORE_BITS-1:0] score;
      logic                  last;
      logic                  none;
      logic                  ovf;
   } kept_word;

   typedef struct {
      bit                  do_cfg;
      logic [THR_BITS-1:0] thr;
      box_word             box;
      bit                  typed;
      kept_word            kept;
   } dir_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [COORD_BITS-1:0] req_box_x = '0;
   logic [COORD_BITS-1:0] req_box_y = '0;
   logic [SIZE_BITS-1:0]  req_box_width = '0;
   logic [SIZE_BITS-1:0]  req_box_height = '0;
   logic [SCORE_BITS-1:0] req_score = '0;
   logic                  req_final_box = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [THR_BITS-1:0]   csr_data = '0;
   logic                  rsp_strobe;
   logic [COORD_BITS-1:0] rsp_kept_x;
   logic [COORD_BITS-1:0] rsp_kept_y;
   logic [SIZE_BITS-1:0]  rsp_kept_width;
   logic [SIZE_BITS-1:0]  rsp_kept_height;
   logic [SCORE_BITS-1:0] rsp_kept_score;
   logic                  rsp_last_kept;
   logic                  rsp_none_kept;
   logic                  rsp_overflowed;

   greedy_box_nms u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_box_x(req_box_x), .req_box_y(req_box_y),
      .req_box_width(req_box_width), .req_box_height(req_box_height),
      .req_score(req_score), .req_final_box(req_final_box),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_kept_x(rsp_kept_x), .rsp_kept_y(rsp_kept_y),
      .rsp_kept_width(rsp_kept_width), .rsp_kept_height(rsp_kept_height),
      .rsp_kept_score(rsp_kept_score), .rsp_last_kept(rsp_last_kept),
      .rsp_none_kept(rsp_none_kept), .rsp_overflowed(rsp_overflowed)
   );

   always #5 clock = ~clock;

   // model of the block
   box_type               set_box[MAX_BOXES];
   logic [SCORE_BITS-1:0] set_score[MAX_BOXES];
   int                    set_count = 0;
   bit                    set_ovf = 1'b0;
   logic [THR_BITS-1:0]   nms_thr = THR_RESET;
   kept_word              kept_q[$];
   int                    errors = 0;
   int                    sent = 0;
   int                    idle_pct = 0;

   function automatic longint unsigned span(longint unsigned a0, longint unsigned al,
                                            longint unsigned b0, longint unsigned bl);
      longint unsigned lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic bit too_close(box_type a, box_type b);
      longint unsigned inter, uni;
      inter = span(a.x, a.w, b.x, b.w) * span(a.y, a.h, b.y, b.h);
      if (inter == 0) return 1'b0;
      uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
      return inter * 256 > longint'(nms_thr) * uni;
   endfunction

   // loads one box; on the last box of a set, runs suppression and returns the kept list
   function automatic void load_box(box_word b, ref kept_word res[$]);
      bit visited[MAX_BOXES];
      int order[$];
      int best;
      bit hit;
      kept_word k;
      res.delete();
      if (b.w != 0 && b.h != 0) begin
         if (set_count < MAX_BOXES) begin
            set_box[set_count] = '{x: b.x, y: b.y, w: b.w, h: b.h};
            set_score[set_count] = b.score;
            set_count++;
         end else begin
            set_ovf = 1'b1;
         end
      end
      if (!b.fin) return;
      foreach (visited[i]) visited[i] = 1'b0;
      for (int r = 0; r < set_count; r++) begin
         best = -1;
         for (int i = 0; i < set_count; i++)
            if (!visited[i] && (best < 0 || set_score[i] > set_score[best])) best = i;
         visited[best] = 1'b1;
         hit = 1'b0;
         foreach (order[j]) if (!hit) hit = too_close(set_box[best], set_box[order[j]]);
         if (!hit) order.push_back(best);
      end
      if (order.size() == 0) begin
         res.push_back('{x: 0, y: 0, w: 0, h: 0, score: 0, last: 1, none: 1, ovf: set_ovf});
      end else begin
         foreach (order[j]) begin
            k.x = set_box[order[j]].x;
            k.y = set_box[order[j]].y;
            k.w = set_box[order[j]].w;
            k.h = set_box[order[j]].h;
            k.score = set_score[order[j]];
            k.last = (j == order.size() - 1);
            k.none = 1'b0;
            k.ovf = set_ovf;
            res.push_back(k);
         end
      end
      set_count = 0;
      set_ovf = 1'b0;
   endfunction

   task automatic send_box(box_word b, bit typed, kept_word tk);
      kept_word res[$];
      req_box_x <= b.x;
      req_box_y <= b.y;
      req_box_width <= b.w;
      req_box_height <= b.h;
      req_score <= b.score;
      req_final_box <= b.fin;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      load_box(b, res);
      if (typed) kept_q.push_back(tk);
      else foreach (res[i]) kept_q.push_back(res[i]);
      sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // only between sets, once the last kept box is out
   task automatic write_thr(logic [THR_BITS-1:0] v);
      start <= 1'b0;
      @(posedge clock);
      while (kept_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      nms_thr = v;
   endtask

   task automatic run_set(int n);
      box_word b;
      int cx, cy, dx, dy;
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            b.x = COORD_BITS'($urandom);
            b.y = COORD_BITS'($urandom);
            b.w = SIZE_BITS'($urandom_range(0, 4096));
            b.h = SIZE_BITS'($urandom_range(0, 4096));
         end else begin
            dx = cx + $urandom_range(0, 40);
            dy = cy + $urandom_range(0, 40);
            b.x = COORD_BITS'((dx > 4095) ? 4095 : dx);
            b.y = COORD_BITS'((dy > 4095) ? 4095 : dy);
            b.w = SIZE_BITS'($urandom_range(1, 120));
            b.h = SIZE_BITS'($urandom_range(1, 120));
            if ($urandom_range(0, 19) == 0) b.w = '0;
            if ($urandom_range(0, 19) == 0) b.h = '0;
         end
         b.score = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
         b.fin = (i == n - 1);
         send_box(b, 1'b0, '{default: 0});
      end
   endtask

   always @(posedge clock) begin
      kept_word e;
      if (!reset && rsp_strobe) begin
         if (kept_q.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = kept_q.pop_front();
            if (rsp_kept_x !== e.x) begin
               $error("kept_x exp %0d got %0d", e.x, rsp_kept_x); errors++;
            end
            if (rsp_kept_y !== e.y) begin
               $error("kept_y exp %0d got %0d", e.y, rsp_kept_y); errors++;
            end
            if (rsp_kept_width !== e.w) begin
               $error("kept_width exp %0d got %0d", e.w, rsp_kept_width); errors++;
            end
            if (rsp_kept_height !== e.h) begin
               $error("kept_height exp %0d got %0d", e.h, rsp_kept_height); errors++;
            end
            if (rsp_kept_score !== e.score) begin
               $error("kept_score exp %0d got %0d", e.score, rsp_kept_score); errors++;
            end
            if (rsp_last_kept !== e.last) begin
               $error("last_kept exp %0d got %0d", e.last, rsp_last_kept); errors++;
            end
            if (rsp_none_kept !== e.none) begin
               $error("none_kept exp %0d got %0d", e.none, rsp_none_kept); errors++;
            end
            if (rsp_overflowed !== e.ovf) begin
               $error("overflowed exp %0d got %0d", e.ovf, rsp_overflowed); errors++;
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      dir_row dir_tab[$];
      int base;
      logic [THR_BITS-1:0] thr_pick[4];
      // empty final box on an empty store gives the marker
      dir_tab.push_back('{0, 0, '{5, 5, 0, 9, 100, 1}, 1,
                         '{0, 0, 0, 0, 0, 1, 1, 0}});
      dir_tab.push_back('{0, 0, '{4095, 4095, 4096, 4096, 65535, 1}, 1,
                         '{4095, 4095, 4096, 4096, 65535, 1, 0, 0}});
      dir_tab.push_back('{0, 0, '{0, 0, 1, 1, 0, 1}, 1, '{0, 0, 1, 1, 0, 1, 0, 0}});
      // equal scores: earlier arrival wins
      dir_tab.push_back('{0, 0, '{10, 10, 50, 50, 700, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{12, 10, 50, 50, 700, 1}, 0, '{default: 0}});
      // zero height dropped mid-set, then the empty final still runs
      dir_tab.push_back('{0, 0, '{100, 100, 30, 30, 5, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{100, 100, 30, 0, 9, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{110, 105, 30, 30, 8, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{400, 400, 20, 20, 3, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{0, 0, 0, 0, 0, 1}, 0, '{default: 0}});
      // threshold zero: touching edges survive, any overlap suppresses
      dir_tab.push_back('{1, 0, '{200, 200, 10, 10, 50, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{210, 200, 10, 10, 40, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{219, 209, 10, 10, 60, 1}, 0, '{default: 0}});
      // threshold 256: identical boxes all kept
      dir_tab.push_back('{1, 256, '{4000, 50, 4096, 8, 1, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{4000, 50, 4096, 8, 2, 1}, 0, '{default: 0}});
      dir_tab.push_back('{1, 511, '{7, 7, 20, 20, 4, 0}, 0, '{default: 0}});
      dir_tab.push_back('{0, 0, '{7, 7, 20, 20, 4, 1}, 0, '{default: 0}});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].do_cfg) write_thr(dir_tab[i].thr);
         send_box(dir_tab[i].box, dir_tab[i].typed, dir_tab[i].kept);
      end
      write_thr(THR_RESET);

      base = sent;
      thr_pick = '{0, 256, 511, 128};
      while (sent - base < 250) begin
         if (sent - base < 83) idle_pct = 29;
         else if (sent - base < 166) idle_pct = 79;
         else idle_pct = 0;
         if ($urandom_range(0, 3) == 0)
            write_thr($urandom_range(0, 1) ? thr_pick[$urandom_range(0, 3)] :
                      THR_BITS'($urandom_range(0, 256)));
         // one set well past capacity to hit the overflow path
         if (sent - base >= 120 && sent - base < 128) run_set(MAX_BOXES + 16);
         else run_set($urandom_range(1, 8));
      end
      start <= 1'b0;
      @(posedge clock);
      while (kept_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
